/* src/pxk_pkg.sv */
// Package for the xorshift/KISS random generator: types, codes, constants
// and the one-step generator function. No dependencies.
`timescale 1ns / 1ps

package pxk_pkg;

    // Command codes of an input word
    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Generator select codes
    localparam logic GEN_XORSHIFT = 1'b0;
    localparam logic GEN_KISS     = 1'b1;

    // Output format codes
    localparam logic [1:0] FMT_RAW32 = 2'd0;
    localparam logic [1:0] FMT_RAW64 = 2'd1;
    localparam logic [1:0] FMT_F32   = 2'd2;
    localparam logic [1:0] FMT_F64   = 2'd3;

    // Configuration register indexes
    localparam logic REG_GEN_SEL = 1'b0;
    localparam logic REG_FORMAT  = 1'b1;

    localparam int NUM_WORDS = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [31:0] KISS_INC = 32'd1411392427;
    localparam logic [31:0] LOW31    = 32'h7FFF_FFFF;

    // Exponent of a value whose leading one sits at the top mantissa bit,
    // minus the leading-zero count of the left-aligned mantissa
    localparam logic [7:0]  EXP32_TOP = 8'd126;
    localparam logic [10:0] EXP64_TOP = 11'd1022;

    typedef logic [NUM_WORDS-1:0][31:0] t_words;

    // Result of one generator step: new state and the two factors of the
    // output word (KISS passes its sum with a factor of one)
    typedef struct packed {
        t_words      next;
        logic [31:0] fa;
        logic [31:0] fb;
    } t_step;

    // One queued draw: format and the factors of the first and second step
    typedef struct packed {
        logic [1:0]  fmt;
        logic [31:0] a0;
        logic [31:0] b0;
        logic [31:0] a1;
        logic [31:0] b1;
    } t_job;

    function automatic t_step gen_step(t_words w, logic gen);
        t_step       res;
        logic [31:0] t;
        logic [31:0] y;
        logic [31:0] s;
        res = '0;
        t   = '0;
        y   = '0;
        s   = '0;
        if (gen == GEN_KISS) begin
            y = w[1] ^ (w[1] << 5);
            y = y ^ (y >> 7);
            y = y ^ (y << 22);
            s = w[2] + w[3] + w[4];
            res.next[0] = w[0] + KISS_INC;
            res.next[1] = y;
            res.next[2] = w[3];
            res.next[3] = s & LOW31;
            res.next[4] = {31'd0, s[31]};
            res.fa = res.next[0] + res.next[1] + res.next[3];
            res.fb = 32'd1;
        end else begin
            t = w[0] ^ (w[0] >> 7);
            res.next[0] = w[1];
            res.next[1] = w[2];
            res.next[2] = w[3];
            res.next[3] = w[4];
            res.next[4] = (w[4] ^ (w[4] << 6)) ^ (t ^ (t << 13));
            res.fa = {w[2][30:0], 1'b1};
            res.fb = res.next[4];
        end
        return res;
    endfunction

endpackage

/* src/pxk_if.sv */
// Handshake channels of the random generator: request and sample words.
// Depends on nothing.
`timescale 1ns / 1ps

interface pxk_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [2:0]  seed_slot;
    logic [31:0] seed_value;

    modport source (output valid, command, seed_slot, seed_value, input ready);
    modport sink   (input valid, command, seed_slot, seed_value, output ready);
endinterface

interface pxk_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] sample;

    modport source (output valid, sample, input ready);
    modport sink   (input valid, sample, output ready);
endinterface

/* src/pxk_front.sv */
// Front end: accepts request words, holds configuration and generator state,
// advances the state and queues the output factors. Uses pxk_pkg.
`timescale 1ns / 1ps

module pxk_front
    import pxk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [1:0] i_cfg_data,
    pxk_req_if.sink    i_req,
    input  logic       i_full,
    output logic       o_push,
    output t_job       o_job
);

    logic       r_gen_sel;
    logic [1:0] r_fmt;
    t_words     r_words;
    t_words     n_words;
    t_step      step_a;
    t_step      step_b;
    logic       accept;
    logic       two_steps;

    // Accept whenever the queue has room
    assign i_req.ready = !i_full;
    assign accept      = i_req.valid && !i_full;
    assign two_steps   = (r_fmt == FMT_RAW64) || (r_fmt == FMT_F64);

    // Two chained steps; the second is used only by 64-bit formats
    assign step_a = gen_step(r_words, r_gen_sel);
    assign step_b = gen_step(step_a.next, r_gen_sel);

    // Next state: load a word, or advance one or two steps
    always_comb begin
        n_words = r_words;
        if (accept) begin
            if (i_req.command == CMD_LOAD) begin
                if (i_req.seed_slot < 3'(NUM_WORDS)) begin
                    n_words[i_req.seed_slot] = i_req.seed_value;
                end
            end else if (two_steps) begin
                n_words = step_b.next;
            end else begin
                n_words = step_a.next;
            end
        end
    end

    // Queue a draw
    assign o_push    = accept && (i_req.command == CMD_DRAW);
    assign o_job.fmt = r_fmt;
    assign o_job.a0  = step_a.fa;
    assign o_job.b0  = step_a.fb;
    assign o_job.a1  = step_b.fa;
    assign o_job.b1  = step_b.fb;

    // Hold configuration and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_sel <= GEN_XORSHIFT;
            r_fmt     <= FMT_RAW32;
            r_words   <= '0;
        end else begin
            r_words <= n_words;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_GEN_SEL) begin
                    r_gen_sel <= i_cfg_data[0];
                end else begin
                    r_fmt <= i_cfg_data;
                end
            end
        end
    end

endmodule

/* src/pxk_queue.sv */
// Short queue of draw jobs between front and back end.
// Uses pxk_pkg.
`timescale 1ns / 1ps

module pxk_queue
    import pxk_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop_ready,
    output t_job o_job
);

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_job            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wp;
    logic [PtrW-1:0] r_rp;
    logic [CntW-1:0] r_cnt;
    logic            pop;

    assign o_full  = (r_cnt == CntW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign pop     = o_valid && i_pop_ready;

    // Write entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* src/pxk_back.sv */
// Back end: multiplies the step factors, normalizes uniform mantissas in two
// stages and holds the sample word for the receiver. Uses pxk_pkg.
`timescale 1ns / 1ps

module pxk_back
    import pxk_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_job     i_job,
    pxk_rsp_if.source o_rsp
);

    // Stage registers
    logic        r_m_vld;
    logic [1:0]  r_m_fmt;
    logic [63:0] r_m_raw;
    logic        r_n_vld;
    logic [1:0]  r_n_fmt;
    logic [63:0] r_n_raw;
    logic [63:0] r_n_x;
    logic [2:0]  r_n_zhi;
    logic        r_n_zero;
    logic        r_o_vld;
    logic [63:0] r_o_sample;

    logic        take_o;
    logic        take_n;
    logic        take_m;
    logic [31:0] prod0;
    logic [31:0] prod1;
    logic [63:0] x0;
    logic [63:0] x1;
    logic [63:0] x2;
    logic [63:0] x3;
    logic [2:0]  zhi;
    logic [63:0] y1;
    logic [63:0] y2;
    logic [63:0] y3;
    logic [2:0]  zlo;
    logic [5:0]  lz;
    logic [7:0]  exp32;
    logic [10:0] exp64;
    logic [63:0] n_sample;

    // Stall chain from the output register backward
    assign take_o  = !r_o_vld || o_rsp.ready;
    assign take_n  = !r_n_vld || take_o;
    assign take_m  = !r_m_vld || take_n;
    assign o_ready = take_m;

    assign prod0 = 32'(i_job.a0 * i_job.b0);
    assign prod1 = 32'(i_job.a1 * i_job.b1);

    // Left-align the mantissa and find the upper three bits of its zero count
    always_comb begin
        if (r_m_fmt == FMT_F64) begin
            x0 = {r_m_raw[63:12], 12'd0};
        end else begin
            x0 = {r_m_raw[63:41], 41'd0};
        end
        zhi[2] = (x0[63:32] == '0);
        x1     = zhi[2] ? (x0 << 32) : x0;
        zhi[1] = (x1[63:48] == '0);
        x2     = zhi[1] ? (x1 << 16) : x1;
        zhi[0] = (x2[63:56] == '0);
        x3     = zhi[0] ? (x2 << 8) : x2;
    end

    // Finish the shift and pack the sample
    always_comb begin
        zlo[2] = (r_n_x[63:60] == '0);
        y1     = zlo[2] ? (r_n_x << 4) : r_n_x;
        zlo[1] = (y1[63:62] == '0);
        y2     = zlo[1] ? (y1 << 2) : y1;
        zlo[0] = !y2[63];
        y3     = zlo[0] ? (y2 << 1) : y2;
        lz     = {r_n_zhi, zlo};
        exp32  = EXP32_TOP - {2'd0, lz};
        exp64  = EXP64_TOP - {5'd0, lz};
        case (r_n_fmt)
            FMT_RAW32: n_sample = {32'd0, r_n_raw[63:32]};
            FMT_RAW64: n_sample = r_n_raw;
            FMT_F32:   n_sample = r_n_zero ? '0 : {32'd0, 1'b0, exp32, y3[62:40]};
            FMT_F64:   n_sample = r_n_zero ? '0 : {1'b0, exp64, y3[62:11]};
            default:   n_sample = r_n_raw;
        endcase
    end

    // Advance stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_n_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (take_m) begin
                r_m_vld <= i_valid;
            end
            if (take_n) begin
                r_n_vld <= r_m_vld;
            end
            if (take_o) begin
                r_o_vld <= r_n_vld;
            end
        end
    end

    // Move payload through the stages
    always_ff @(posedge i_clk) begin
        if (take_m && i_valid) begin
            r_m_fmt <= i_job.fmt;
            r_m_raw <= {prod0, prod1};
        end
        if (take_n && r_m_vld) begin
            r_n_fmt  <= r_m_fmt;
            r_n_raw  <= r_m_raw;
            r_n_x    <= x3;
            r_n_zhi  <= zhi;
            r_n_zero <= (x0 == '0);
        end
        if (take_o && r_n_vld) begin
            r_o_sample <= n_sample;
        end
    end

    assign o_rsp.valid  = r_o_vld;
    assign o_rsp.sample = r_o_sample;

endmodule

/* src/prng_xorshift_kiss_uniform_unit.sv */
// Top level of the xorshift/KISS random generator: front end, job queue and
// back end. Uses pxk_pkg, pxk_req_if, pxk_rsp_if, pxk_front, pxk_queue, pxk_back.
//
// Usage:
//   Requests arrive on i_req (valid/ready). A load word (command 1) writes
//   seed_value into state word seed_slot (slots 5..7 are ignored) and gives
//   no sample. A draw word (command 0) advances the generator one step, or
//   two for the 64-bit formats, and gives one sample word on o_rsp.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 generator select, 1 output format); write only while the block is idle.
//   A draw accepted on i_req passes the queue write, the multiply stage and two
//   normalize stages before its sample shows on o_rsp. Throughput: one word per
//   cycle while o_rsp is not stalled. The state update of both steps completes
//   in the accepting cycle; multiply and normalizing shift are pipelined after.
//   Reset clears all state words, selects xorshift and raw32 output, and
//   empties the queue and pipeline. When the receiver stalls, the sample
//   holds, the pipeline and the two-entry queue fill, then i_req.ready drops.
`timescale 1ns / 1ps

module prng_xorshift_kiss_uniform_unit
    import pxk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [1:0] i_cfg_data,
    pxk_req_if.sink    i_req,
    pxk_rsp_if.source  o_rsp
);

    logic push;
    logic full;
    logic q_valid;
    logic q_ready;
    t_job push_job;
    t_job q_job;

    pxk_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .i_full     (full),
        .o_push     (push),
        .o_job      (push_job)
    );

    pxk_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_job       (push_job),
        .o_full      (full),
        .o_valid     (q_valid),
        .i_pop_ready (q_ready),
        .o_job       (q_job)
    );

    pxk_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_job   (q_job),
        .o_rsp   (o_rsp)
    );

    // Only accepted draw words enter the queue
    a_push_is_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push == (i_req.valid && i_req.ready && (i_req.command == CMD_DRAW)))
        else $error("queue push does not match accepted draw");

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("push into full queue");

    // A draw reaches the queue head no earlier than the next cycle
    a_queue_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!q_valid && !push) |=> !q_valid)
        else $error("queue valid without a push");

    // No sample right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("sample valid after reset");

endmodule

/* bench/prng_xorshift_kiss_uniform_unit_tb.sv */
// Testbench for prng_xorshift_kiss_uniform_unit: drives seed loads and draws
// under random idling, predicts every sample word and checks it in order.
// Depends on pxk_pkg, pxk_req_if, pxk_rsp_if and the unit itself.
`timescale 1ns / 1ps

module prng_xorshift_kiss_uniform_unit_tb;
    import pxk_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int BLOCK_WORDS  = 32;

    // Predicts sample words from its own copy of the generator state and
    // the two registers, and checks them against what the unit returns
    class sample_scoreboard;
        logic [31:0] st [NUM_WORDS];
        logic        gen_sel;
        logic [1:0]  fmt;
        logic [63:0] expected_q [$];
        int          errors;

        function new();
            foreach (st[i]) st[i] = '0;
            gen_sel = GEN_XORSHIFT;
            fmt     = FMT_RAW32;
            errors  = 0;
        endfunction

        function void write_reg(logic idx, logic [1:0] data);
            if (idx == REG_GEN_SEL)
                gen_sel = data[0];
            else
                fmt = data;
        endfunction

        // Advance the selected generator one step, return its 32-bit output
        function logic [31:0] next_word();
            logic [31:0] t;
            logic [31:0] y;
            logic [31:0] w4;
            logic [31:0] r;
            if (gen_sel == GEN_KISS) begin
                y = st[1] ^ (st[1] << 5);
                y = y ^ (y >> 7);
                y = y ^ (y << 22);
                st[1] = y;
                t = st[2] + st[3] + st[4];
                st[2] = st[3];
                st[3] = t & LOW31;
                st[4] = {31'd0, t[31]};
                st[0] = st[0] + KISS_INC;
                r = st[0] + st[1] + st[3];
            end else begin
                t  = st[0] ^ (st[0] >> 7);
                w4 = st[4];
                st[0] = st[1];
                st[1] = st[2];
                st[2] = st[3];
                st[3] = w4;
                st[4] = (w4 ^ (w4 << 6)) ^ (t ^ (t << 13));
                r = (st[1] + st[1] + 32'd1) * st[4];
            end
            return r;
        endfunction

        // Top 23 bits as a fraction in [0,1), encoded as single bits
        function logic [63:0] unit_f32(logic [31:0] r);
            logic [22:0] m;
            logic [22:0] frac;
            logic [7:0]  e;
            int          p;
            m = r[31:9];
            if (m == '0)
                return '0;
            p = 0;
            for (int i = 0; i < 23; i++)
                if (m[i]) p = i;
            e    = 8'(104 + p);
            frac = m << (23 - p);
            return {33'd0, e, frac};
        endfunction

        // Top 52 bits as a fraction in [0,1), encoded as double bits
        function logic [63:0] unit_f64(logic [63:0] r);
            logic [51:0] m;
            logic [51:0] frac;
            logic [10:0] e;
            int          p;
            m = r[63:12];
            if (m == '0)
                return '0;
            p = 0;
            for (int i = 0; i < 52; i++)
                if (m[i]) p = i;
            e    = 11'(971 + p);
            frac = m << (52 - p);
            return {1'b0, e, frac};
        endfunction

        // Apply one accepted request word; draws queue their expected sample
        function void note_word(logic cmd, logic [2:0] slot, logic [31:0] value);
            logic [63:0] r;
            logic [31:0] hi;
            logic [31:0] lo;
            if (cmd == CMD_LOAD) begin
                if (slot < NUM_WORDS)
                    st[slot] = value;
                return;
            end
            case (fmt)
                FMT_RAW32: begin
                    r = {32'd0, next_word()};
                end
                FMT_RAW64: begin
                    hi = next_word();
                    lo = next_word();
                    r  = {hi, lo};
                end
                FMT_F32: begin
                    r = unit_f32(next_word());
                end
                default: begin
                    hi = next_word();
                    lo = next_word();
                    r  = unit_f64({hi, lo});
                end
            endcase
            expected_q.push_back(r);
        endfunction

        function void check_sample(logic [63:0] got);
            logic [63:0] want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected sample word, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                $display("%0t: sample mismatch, expected %h, actual %h", $time, want, got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic        cfg_idx;
    logic [1:0]  cfg_data;
    int unsigned cycles       = 0;
    int          req_idle_pct = 38;
    int          rsp_idle_pct = 60;

    sample_scoreboard sb = new();

    pxk_req_if req_ch ();
    pxk_rsp_if rsp_ch ();

    prng_xorshift_kiss_uniform_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("[prng_xorshift_kiss_uniform_unit] ERROR");
            $finish;
        end
    end

    // Sample side: check accepted words, then stall at random
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
                sb.check_sample(rsp_ch.sample);
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000 >> $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    // Present one request word, idling first at random; note it on acceptance
    task automatic send_word(logic cmd, logic [2:0] slot, logic [31:0] value);
        if ($urandom_range(99) < req_idle_pct) begin
            req_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < req_idle_pct);
        end
        req_ch.valid      <= 1'b1;
        req_ch.command    <= cmd;
        req_ch.seed_slot  <= slot;
        req_ch.seed_value <= value;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_word(cmd, slot, value);
    endtask

    task automatic draw();
        send_word(CMD_DRAW, 3'($urandom_range(7)), $urandom);
    endtask

    // Drop valid and let every expected sample arrive and the pipe drain
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers on consecutive edges while the unit is idle
    task automatic set_mode(logic gen, logic [1:0] fmt);
        logic [1:0] gen_data;
        gen_data = {1'($urandom_range(1)), gen};
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_GEN_SEL;
        cfg_data <= gen_data;
        @(posedge i_clk);
        sb.write_reg(REG_GEN_SEL, gen_data);
        cfg_idx  <= REG_FORMAT;
        cfg_data <= fmt;
        @(posedge i_clk);
        sb.write_reg(REG_FORMAT, fmt);
        cfg_we   <= 1'b0;
    endtask

    task automatic reseed();
        for (int s = 0; s < NUM_WORDS; s++)
            send_word(CMD_LOAD, 3'(s), rand_word());
    endtask

    // Mostly draws, with loads to any slot mixed in
    task automatic random_block(int n);
        repeat (n) begin
            if ($urandom_range(99) < 80)
                draw();
            else
                send_word(CMD_LOAD, 3'($urandom_range(7)), rand_word());
        end
    endtask

    initial begin
        int combo;
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= REG_GEN_SEL;
        cfg_data          <= FMT_RAW32;
        req_ch.valid      <= 1'b0;
        req_ch.command    <= CMD_DRAW;
        req_ch.seed_slot  <= 3'd0;
        req_ch.seed_value <= 32'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero state after reset, then loads to slots past the last word
        draw();
        send_word(CMD_LOAD, 3'd7, 32'hFFFF_FFFF);
        send_word(CMD_LOAD, 3'd5, 32'hFFFF_FFFF);
        send_word(CMD_LOAD, 3'd6, 32'hA5A5_5A5A);
        draw();
        // Extreme seeds, with a full-width word as the KISS carry
        send_word(CMD_LOAD, 3'd0, 32'hFFFF_FFFF);
        send_word(CMD_LOAD, 3'd1, 32'h0000_0000);
        send_word(CMD_LOAD, 3'd2, 32'h8000_0000);
        send_word(CMD_LOAD, 3'd3, 32'h7FFF_FFFF);
        send_word(CMD_LOAD, 3'd4, 32'hFFFF_FFFF);
        draw();

        // Switch generators on the shared state, 64-bit raw
        set_mode(GEN_KISS, FMT_RAW64);
        draw();
        draw();

        // KISS with a zero xorshift word, single-precision uniform
        set_mode(GEN_KISS, FMT_F32);
        send_word(CMD_LOAD, 3'd1, 32'h0000_0000);
        draw();

        // All-zero xorshift gives a zero fraction in both float formats
        set_mode(GEN_XORSHIFT, FMT_F32);
        for (int s = 0; s < NUM_WORDS; s++)
            send_word(CMD_LOAD, 3'(s), 32'd0);
        draw();
        set_mode(GEN_XORSHIFT, FMT_F64);
        draw();
        send_word(CMD_LOAD, 3'd0, 32'hDEAD_BEEF);
        draw();

        // Random part: three idling phases, every register setting in each
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    req_idle_pct = 38;
                    rsp_idle_pct = 60;
                end
                1: begin
                    req_idle_pct = 60;
                    rsp_idle_pct = 38;
                end
                default: begin
                    req_idle_pct = 0;
                    rsp_idle_pct = 0;
                end
            endcase
            for (int c = 0; c < 8; c++) begin
                combo = (c + ph * 3) % 8;
                set_mode(combo[0], combo[2:1]);
                if ((c % 2) == 0)
                    reseed();
                random_block(BLOCK_WORDS);
            end
        end

        wait_idle();
        if (sb.errors == 0)
            $display("[prng_xorshift_kiss_uniform_unit] OK");
        else
            $display("[prng_xorshift_kiss_uniform_unit] ERROR");
        $finish;
    end

endmodule

/* sim.f */
src/pxk_pkg.sv
src/pxk_if.sv
src/pxk_front.sv
src/pxk_queue.sv
src/pxk_back.sv
src/prng_xorshift_kiss_uniform_unit.sv
bench/prng_xorshift_kiss_uniform_unit_tb.sv
